/* design/relocation_fixup_parser_macros.svh */
// Assertion macros shared by the relocation fixup parser RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef RELOCATION_FIXUP_PARSER_MACROS_SVH
`define RELOCATION_FIXUP_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is high
`define RFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated during reset
`define RFP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RFP_ASSERT(label, clk, rst, prop, msg)

`define RFP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* design/rfp_pkg.sv */
`default_nettype none

package rfp_pkg;

   // Field widths
   localparam int unsigned HALF_W    = 16;
   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned OFFSET_W  = 12;
   localparam int unsigned ETYPE_W   = 4;
   localparam int unsigned COUNT_W   = 31;

   // Entry types
   localparam logic [ETYPE_W-1:0] TYPE_ABSOLUTE = 4'd0;
   localparam logic [ETYPE_W-1:0] TYPE_HIGHLOW  = 4'd3;

   // Result status codes
   typedef enum logic [1:0] {
      ST_APPLY       = 2'd0,
      ST_UNSUPPORTED = 2'd1,
      ST_END         = 2'd2,
      ST_MALFORMED   = 2'd3
   } status_type;

   // Parser phase
   typedef enum logic [2:0] {
      PH_PAGE_LO = 3'd0,
      PH_PAGE_HI = 3'd1,
      PH_SIZE_LO = 3'd2,
      PH_SIZE_HI = 3'd3,
      PH_ENTRIES = 3'd4
   } phase_type;

   // One parse result for the output stage
   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [ADDR_W-1:0]   image_offset;
      logic [ETYPE_W-1:0]  entry_type;
   } result_type;

endpackage

`default_nettype wire

/* design/rfp_parser.sv */
`default_nettype none

`include "relocation_fixup_parser_macros.svh"

// Header/entry parser: consumes one halfword per advance and produces
// at most one result word for the same cycle.
module rfp_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [rfp_pkg::HALF_W-1:0]    half_word,
   output rfp_pkg::result_type                result
);

   rfp_pkg::phase_type               phase_ff, phase_in;
   logic [rfp_pkg::ADDR_W-1:0]       page_base_ff, page_base_in;
   logic [rfp_pkg::HALF_W-1:0]       size_low_ff, size_low_in;
   logic [rfp_pkg::COUNT_W-1:0]      entries_left_ff, entries_left_in;

   logic [rfp_pkg::ADDR_W-1:0]       block_size;
   logic [rfp_pkg::COUNT_W-1:0]      size_entries;
   logic [rfp_pkg::COUNT_W-1:0]      left_dec;
   logic [rfp_pkg::ETYPE_W-1:0]      etype;
   logic [rfp_pkg::ADDR_W-1:0]       entry_addr;
   logic                             size_zero;
   logic                             size_bad;

   // Shared datapath terms
   assign block_size   = {half_word, size_low_ff};
   assign size_zero    = (block_size == '0);
   assign size_bad     = block_size[0] || (block_size[rfp_pkg::ADDR_W-1:3] == '0);
   assign size_entries = block_size[rfp_pkg::ADDR_W-1:1] - rfp_pkg::COUNT_W'(4);
   assign left_dec     = entries_left_ff - rfp_pkg::COUNT_W'(1);
   assign etype        = half_word[rfp_pkg::HALF_W-1 -: rfp_pkg::ETYPE_W];
   assign entry_addr   = page_base_ff
                       + {{(rfp_pkg::ADDR_W-rfp_pkg::OFFSET_W){1'b0}},
                          half_word[rfp_pkg::OFFSET_W-1:0]};

   // Next state
   always_comb begin
      phase_in        = phase_ff;
      page_base_in    = page_base_ff;
      size_low_in     = size_low_ff;
      entries_left_in = entries_left_ff;
      if (advance) begin
         unique case (phase_ff)
            rfp_pkg::PH_PAGE_HI: begin
               page_base_in = {half_word, page_base_ff[rfp_pkg::HALF_W-1:0]};
               phase_in     = rfp_pkg::PH_SIZE_LO;
            end
            rfp_pkg::PH_SIZE_LO: begin
               size_low_in = half_word;
               phase_in    = rfp_pkg::PH_SIZE_HI;
            end
            rfp_pkg::PH_SIZE_HI: begin
               if (size_zero || size_bad) begin
                  phase_in = rfp_pkg::PH_PAGE_LO;
               end else begin
                  entries_left_in = size_entries;
                  phase_in = (size_entries == '0) ? rfp_pkg::PH_PAGE_LO
                                                  : rfp_pkg::PH_ENTRIES;
               end
            end
            rfp_pkg::PH_ENTRIES: begin
               entries_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = rfp_pkg::PH_PAGE_LO;
               end
            end
            default: begin
               // page low halfword; unused codes behave the same
               page_base_in = {{(rfp_pkg::ADDR_W-rfp_pkg::HALF_W){1'b0}}, half_word};
               phase_in     = rfp_pkg::PH_PAGE_HI;
            end
         endcase
      end
   end

   // Result decode
   always_comb begin
      result.valid        = 1'b0;
      result.status       = rfp_pkg::ST_APPLY;
      result.image_offset = '0;
      result.entry_type   = '0;
      unique case (phase_ff)
         rfp_pkg::PH_SIZE_HI: begin
            if (size_zero) begin
               result.valid  = 1'b1;
               result.status = rfp_pkg::ST_END;
            end else if (size_bad) begin
               result.valid  = 1'b1;
               result.status = rfp_pkg::ST_MALFORMED;
            end
         end
         rfp_pkg::PH_ENTRIES: begin
            result.image_offset = entry_addr;
            result.entry_type   = etype;
            if (etype == rfp_pkg::TYPE_HIGHLOW) begin
               result.valid  = 1'b1;
               result.status = rfp_pkg::ST_APPLY;
            end else if (etype != rfp_pkg::TYPE_ABSOLUTE) begin
               result.valid  = 1'b1;
               result.status = rfp_pkg::ST_UNSUPPORTED;
            end
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= rfp_pkg::PH_PAGE_LO;
         page_base_ff    <= '0;
         size_low_ff     <= '0;
         entries_left_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         page_base_ff    <= page_base_in;
         size_low_ff     <= size_low_in;
         entries_left_ff <= entries_left_in;
      end
   end

   // Entry phase never runs with an empty count
   `RFP_ASSERT(a_entries_nonzero, clock, reset,
      (phase_ff == rfp_pkg::PH_ENTRIES) |-> (entries_left_ff != '0),
      "entry phase with zero entries left")

   // Size halfword leads back to a header or into entries
   `RFP_ASSERT(a_size_exit, clock, reset,
      (advance && phase_ff == rfp_pkg::PH_SIZE_HI)
         |=> (phase_ff == rfp_pkg::PH_PAGE_LO || phase_ff == rfp_pkg::PH_ENTRIES),
      "bad phase after block size")

   // Header address halfwords never produce a result
   `RFP_ASSERT(a_result_phase, clock, reset,
      result.valid |-> (phase_ff == rfp_pkg::PH_SIZE_HI || phase_ff == rfp_pkg::PH_ENTRIES),
      "result raised outside size or entry phase")

endmodule

`default_nettype wire

/* design/relocation_fixup_parser.sv */
// Base-relocation table fixup parser.
// req channel: one little-endian halfword of the relocation table per word,
//   taken when req_valid and req_ready are both high. Each block is an
//   8-byte header (page address, block size, low halfword first) and then
//   16-bit entries (type in bits 15..12, page offset in bits 11..0).
// rsp channel: at most one word per input halfword: status, image_offset,
//   entry_type. Highlow entries give an apply command, absolute entries and
//   header halfwords give nothing, other types give an unsupported status;
//   a zero size gives end of table, an odd size or one below 8 a malformed
//   status, and both re-arm the parser for a new table.
// csr channel: writes load_delta, always ready; the consumer adds it to the
//   word at image_offset. Write it only while the block is idle.
// A result is registered and appears on rsp in the cycle after its halfword is taken.
// Throughput: one halfword per cycle, set by the single output register.
// When the receiver stalls, the pending result holds and req_ready drops
//   until it is taken; req_ready also stays high in the cycle it is taken.
// Reset (synchronous): parser returns to the first header halfword, the
//   output register empties and load_delta clears to zero.
`default_nettype none

`include "relocation_fixup_parser_macros.svh"

module relocation_fixup_parser (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [rfp_pkg::HALF_W-1:0]         req_half_word,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic [rfp_pkg::ADDR_W-1:0]              rsp_image_offset,
   output logic [rfp_pkg::ETYPE_W-1:0]             rsp_entry_type,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic signed [rfp_pkg::ADDR_W-1:0]  csr_load_delta
);

   rfp_pkg::result_type                result;
   logic                               req_take;
   logic                               rsp_valid_ff, rsp_valid_in;
   rfp_pkg::status_type                status_ff;
   logic [rfp_pkg::ADDR_W-1:0]         offset_ff;
   logic [rfp_pkg::ETYPE_W-1:0]        etype_ff;
   logic signed [rfp_pkg::ADDR_W-1:0]  load_delta_ff;

   // Handshake: take a word whenever the output slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   rfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_take),
      .half_word (req_half_word),
      .result    (result)
   );

   // Output slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = result.valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (req_take && result.valid) begin
         status_ff <= result.status;
         offset_ff <= result.image_offset;
         etype_ff  <= result.entry_type;
      end
   end

   // Delta register, held for the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         load_delta_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         load_delta_ff <= csr_load_delta;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_image_offset = offset_ff;
   assign rsp_entry_type   = etype_ff;

   // End and malformed words carry a zero offset
   `RFP_ASSERT(a_end_zero_offset, clock, reset,
      (req_take && result.valid &&
       (result.status == rfp_pkg::ST_END || result.status == rfp_pkg::ST_MALFORMED))
         |=> (rsp_image_offset == '0 && rsp_entry_type == '0),
      "end or malformed word with nonzero offset or type")

   // A csr write lands in the delta register
   `RFP_ASSERT(a_delta_write, clock, reset,
      csr_valid |=> (load_delta_ff == $past(csr_load_delta)),
      "load_delta not updated by csr write")

   // Input stalls only behind a blocked result
   `RFP_ASSERT_ALWAYS(a_ready_stall, clock,
      !req_ready |-> (rsp_valid_ff && !rsp_ready),
      "req_ready low without a stalled result")

endmodule

`default_nettype wire

/* bench/fixup_checker.sv */
module fixup_checker
   import rfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [HALF_W-1:0]         req_half_word,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_status,
   input  logic [ADDR_W-1:0]         rsp_image_offset,
   input  logic [ETYPE_W-1:0]        rsp_entry_type,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic signed [ADDR_W-1:0]  csr_load_delta,
   output int                        mismatches,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // One fixup command as it should leave the block
   typedef struct {
      status_type          status;
      logic [ADDR_W-1:0]   image_offset;
      logic [ETYPE_W-1:0]  entry_type;
   } fixup_word;

   fixup_word pending_fixups[$];

   // Parser state tracked alongside the block
   phase_type           parse_phase;
   logic [ADDR_W-1:0]   page_addr;
   logic [HALF_W-1:0]   size_low;
   logic [COUNT_W-1:0]  entries_remaining;
   // Held only; the consumer applies it, so no output depends on it
   logic signed [ADDR_W-1:0] delta_copy;
   int results_seen;

   // Advance the parser by one halfword; returns 1 when a word is due
   function automatic bit parse_half(input logic [HALF_W-1:0] hw, output fixup_word w);
      logic [ADDR_W-1:0]  block_size;
      logic [ADDR_W-1:0]  body_bytes;
      logic [ETYPE_W-1:0] kind;
      bit                 produced;
      produced = 1'b0;
      w.status = ST_APPLY;
      w.image_offset = '0;
      w.entry_type = '0;
      block_size = {hw, size_low};
      body_bytes = block_size - 32'd8;
      kind = hw[15:12];
      case (parse_phase)
         PH_PAGE_HI: begin
            page_addr[31:16] = hw;
            parse_phase = PH_SIZE_LO;
         end
         PH_SIZE_LO: begin
            size_low = hw;
            parse_phase = PH_SIZE_HI;
         end
         PH_SIZE_HI: begin
            parse_phase = PH_PAGE_LO;
            if (block_size == '0) begin
               // zero size closes the table
               w.status = ST_END;
               produced = 1'b1;
            end else if (block_size[0] || block_size < 32'd8) begin
               w.status = ST_MALFORMED;
               produced = 1'b1;
            end else begin
               // an 8-byte block carries no entries and goes straight to the next header
               entries_remaining = body_bytes[31:1];
               if (entries_remaining != '0) parse_phase = PH_ENTRIES;
            end
         end
         PH_ENTRIES: begin
            w.image_offset = page_addr + {20'd0, hw[OFFSET_W-1:0]};
            w.entry_type = kind;
            entries_remaining = entries_remaining - 1'b1;
            if (entries_remaining == '0) parse_phase = PH_PAGE_LO;
            if (kind == TYPE_HIGHLOW) begin
               w.status = ST_APPLY;
               produced = 1'b1;
            end else if (kind != TYPE_ABSOLUTE) begin
               w.status = ST_UNSUPPORTED;
               produced = 1'b1;
            end
         end
         default: begin
            page_addr = {16'd0, hw};
            parse_phase = PH_PAGE_HI;
         end
      endcase
      return produced;
   endfunction

   // Watch all three channels at each edge
   always @(posedge clock) begin : watch
      fixup_word predicted;
      fixup_word want;
      if (reset) begin
         parse_phase = PH_PAGE_LO;
         page_addr = '0;
         size_low = '0;
         entries_remaining = '0;
         delta_copy = '0;
         pending_fixups.delete();
         results_seen = 0;
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) delta_copy = csr_load_delta;
         if (req_valid && req_ready) begin
            if (parse_half(req_half_word, predicted)) pending_fixups.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_fixups.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t word %0d: none due, got status %0d offset %h type %0d",
                           $realtime, results_seen, rsp_status, rsp_image_offset,
                           rsp_entry_type);
            end else begin
               want = pending_fixups.pop_front();
               if (rsp_status !== want.status || rsp_image_offset !== want.image_offset ||
                   rsp_entry_type !== want.entry_type) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t word %0d: expected status %0d offset %h type %0d, %s",
                              $realtime, results_seen, want.status, want.image_offset,
                              want.entry_type,
                              $sformatf("got status %0d offset %h type %0d",
                                        rsp_status, rsp_image_offset, rsp_entry_type));
               end
            end
         end
      end
      outstanding = pending_fixups.size();
   end

endmodule

/* bench/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rfp_pkg::*;

   localparam int ITEM_TARGET    = 1700;
   localparam int QUIET_FROM     = 1450;
   localparam int PRESSURE_AT    = 600;
   localparam int HOLD_CYCLES    = 300;
   localparam int CFG_SPACING    = 350;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic [HALF_W-1:0]         req_half_word = '0;
   logic                      rsp_ready = 1'b0;
   logic                      csr_valid = 1'b0;
   logic signed [ADDR_W-1:0]  csr_load_delta = '0;
   logic                      req_ready;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [ADDR_W-1:0]         rsp_image_offset;
   logic [ETYPE_W-1:0]        rsp_entry_type;
   logic                      csr_ready;

   int mismatches;
   int outstanding;
   int halves_sent = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_ask = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   relocation_fixup_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_half_word    (req_half_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_image_offset (rsp_image_offset),
      .rsp_entry_type   (rsp_entry_type),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_load_delta   (csr_load_delta)
   );

   fixup_checker monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_half_word    (req_half_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_image_offset (rsp_image_offset),
      .rsp_entry_type   (rsp_entry_type),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_load_delta   (csr_load_delta),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // Watchdog: too long without any word moving ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stall bursts, calm stretches, one long hold-off
   initial begin : receiver
      int burst;
      int calm;
      burst = 0;
      calm = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_ready <= 1'b0;
         end else if (calm > 0) begin
            calm--;
            rsp_ready <= 1'b1;
         end else begin
            case ($urandom_range(0, 19))
               0, 1: begin
                  burst = $urandom_range(0, 15);
                  rsp_ready <= 1'b0;
               end
               2: begin
                  calm = $urandom_range(20, 100);
                  rsp_ready <= 1'b1;
               end
               default: rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // Offer one halfword, with an occasional gap ahead of it
   task automatic push_half(input logic [HALF_W-1:0] hw);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_half_word <= hw;
      do @(posedge clock); while (!req_ready);
      halves_sent++;
   endtask

   task automatic send_header(input logic [ADDR_W-1:0] page, input logic [ADDR_W-1:0] size);
      push_half(page[15:0]);
      push_half(page[31:16]);
      push_half(size[15:0]);
      push_half(size[31:16]);
   endtask

   // Entry biased toward highlow and absolute, any offset
   function automatic logic [HALF_W-1:0] pick_entry();
      int roll;
      logic [ETYPE_W-1:0] kind;
      roll = $urandom_range(0, 99);
      if (roll < 40) kind = TYPE_HIGHLOW;
      else if (roll < 55) kind = TYPE_ABSOLUTE;
      else kind = ETYPE_W'($urandom_range(0, 15));
      return {kind, OFFSET_W'($urandom)};
   endfunction

   // One whole block: mostly well formed, some table ends, some broken headers
   task automatic send_block();
      int pick;
      int count;
      logic [ADDR_W-1:0] block_size;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         count = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
         block_size = 32'd8 + 32'(2 * count);
         send_header($urandom, block_size);
         repeat (count) push_half(pick_entry());
      end else if (pick < 88) begin
         send_header($urandom, 32'd0);
      end else begin
         block_size = $urandom;
         if ($urandom_range(0, 1) == 0) block_size[31:4] = '0;
         // keep any accidental well-formed size short
         if (!block_size[0] && block_size > 32'd136) block_size[0] = 1'b1;
         send_header($urandom, block_size);
         count = (block_size >= 32'd8 && !block_size[0]) ? int'((block_size - 32'd8) >> 1) : 0;
         repeat (count) push_half(HALF_W'($urandom));
      end
   endtask

   // Let every due word arrive and the pipe empty before touching the register
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_delta(input logic signed [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_load_delta <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int next_cfg;
      int cfg_round;
      bit pressured;
      pressured = 1'b0;
      cfg_round = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_delta(32'sh7FFF_FFFF);

      // Page near the top so the highlow offset wraps; every status class
      send_header(32'hFFFF_F800, 32'd18);
      push_half(16'h3FFF);
      push_half(16'h0123);
      push_half(16'hA000);
      push_half(16'hF7FF);
      push_half(16'h3000);
      // block of exactly eight bytes: no entries
      send_header(32'h0000_1234, 32'd8);
      // end of table
      send_header(32'h0000_0000, 32'd0);
      // odd size with a high upper half
      send_header(32'hAAAA_5555, 32'h8000_0013);
      // even size below eight
      send_header(32'hFFFF_FFFF, 32'd6);

      settle();
      write_delta(32'sh8000_0000);

      next_cfg = halves_sent + CFG_SPACING;
      while (halves_sent < ITEM_TARGET) begin
         if (halves_sent >= QUIET_FROM) quiet = 1'b1;
         if (!pressured && halves_sent >= PRESSURE_AT) begin
            hold_ask = 1'b1;
            pressured = 1'b1;
         end
         send_block();
         if (halves_sent >= next_cfg && halves_sent < ITEM_TARGET) begin
            settle();
            write_delta(cfg_round == 0 ? 32'sd0 : $urandom);
            cfg_round++;
            next_cfg = halves_sent + CFG_SPACING;
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
